FILE: rtl/ntss_pkg.sv
// shared types, codes and tag size tables for the nested tag stream serializer
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package ntss_pkg;

    localparam int STACK_DEPTH_DEF  = 16;
    localparam int ADDRESS_BITS_DEF = 16;
    localparam int CAP_W            = 17;
    localparam logic [CAP_W-1:0] CAP_RESET = 17'h10000;
    localparam int IN_TDATA_W       = 128;
    localparam int OUT_TDATA_W      = 32;

    typedef enum logic [2:0] {
        OP_BEGIN_COMPOUND = 3'd0,
        OP_END_COMPOUND   = 3'd1,
        OP_BEGIN_LIST     = 3'd2,
        OP_END_LIST       = 3'd3,
        OP_ADD_TAG        = 3'd4,
        OP_NAME_BYTE      = 3'd5,
        OP_ARRAY_ELEMENT  = 3'd6,
        OP_UNUSED         = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK            = 3'd0,
        ST_BAD_CONTEXT   = 3'd1,
        ST_TYPE_MISMATCH = 3'd2,
        ST_TOO_DEEP      = 3'd3,
        ST_BUFFER_FULL   = 3'd4,
        ST_BAD_SEQUENCE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CTX_ROOT     = 2'd0,
        CTX_COMPOUND = 2'd1,
        CTX_LIST     = 2'd2
    } ctx_t;

    typedef enum logic [1:0] {
        EM_IDLE   = 2'd0,
        EM_HEAD   = 2'd1,
        EM_APPEND = 2'd2,
        EM_STATUS = 2'd3
    } emit_state_t;

    localparam logic [3:0] TAG_NONE     = 4'd0;
    localparam logic [3:0] TAG_STRING   = 4'd8;
    localparam logic [3:0] TAG_LIST     = 4'd9;
    localparam logic [3:0] TAG_COMPOUND = 4'd10;

    // one command's bytes: list head rewrite, then appended bytes, then status
    typedef struct packed {
        status_t      status;
        logic [2:0]   rw_n;
        logic [39:0]  rw_data;
        logic [3:0]   ap_n;
        logic [95:0]  ap_data;
    } plan_t;

    typedef struct packed {
        logic push;
        logic pop;
    } stack_op_t;

    // bytes written after the name of a tag
    function automatic logic [3:0] tail_len(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd1:          r = 4'd1;
            4'd2:          r = 4'd2;
            4'd3, 4'd5:    r = 4'd4;
            4'd4, 4'd6:    r = 4'd8;
            4'd7:          r = 4'd4;
            4'd8:          r = 4'd2;
            4'd9:          r = 4'd5;
            4'd11, 4'd12:  r = 4'd4;
            default:       r = 4'd0;
        endcase
        return r;
    endfunction

    // bytes per array element
    function automatic logic [3:0] elem_len(input logic [3:0] k);
        logic [3:0] r;
        case (k)
            4'd7, 4'd8: r = 4'd1;
            4'd11:      r = 4'd4;
            4'd12:      r = 4'd8;
            default:    r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic tag_known(input logic [3:0] k);
        return (k >= 4'd1 && k <= 4'd8) || k == 4'd11 || k == 4'd12;
    endfunction

endpackage

FILE: rtl/ntss_stack.sv
// nesting stack memory: one write port, one registered read port
// uses ntss_pkg
`timescale 1ns / 1ps

module ntss_stack import ntss_pkg::*; #(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF,
    parameter int ENTRY_W     = 54
) (
    input  logic                           aclk,
    input  logic                           we,
    input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
    input  logic [ENTRY_W-1:0]             wdata,
    input  logic                           re,
    input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
    output logic [ENTRY_W-1:0]             rdata
);

    logic [ENTRY_W-1:0] mem [STACK_DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/ntss_decode.sv
// command decoder: checks one command against the stack top and buffer room,
// builds its byte plan and the next state; uses ntss_pkg
`timescale 1ns / 1ps

module ntss_decode import ntss_pkg::*; #(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  opcode_t                         op,
    input  logic [3:0]                      tag_type,
    input  logic [14:0]                     name_length,
    input  logic [63:0]                     scalar_value,
    input  logic [30:0]                     array_length,
    input  logic [7:0]                      data_byte,
    input  ctx_t                            top_ctx,
    input  logic [3:0]                      top_ltype,
    input  logic [31:0]                     top_count,
    input  logic [ADDRESS_BITS-1:0]         top_head,
    input  logic [$clog2(STACK_DEPTH)-1:0]  depth,
    input  logic [ADDRESS_BITS-1:0]         wofs,
    input  logic [14:0]                     names_rem,
    input  logic [30:0]                     elem_rem,
    input  logic [63:0]                     def_val,
    input  logic [3:0]                      def_kind,
    input  logic [CAP_W-1:0]                capacity,
    output plan_t                           plan,
    output logic [ADDRESS_BITS-1:0]         rw_addr,
    output logic [ADDRESS_BITS-1:0]         ap_addr,
    output stack_op_t                       sop,
    output logic [3:0]                      mod_ltype,
    output logic [31:0]                     mod_count,
    output ctx_t                            ctx_next,
    output logic [3:0]                      ltype_next,
    output logic [31:0]                     count_next,
    output logic [ADDRESS_BITS-1:0]         head_next,
    output logic [$clog2(STACK_DEPTH)-1:0]  depth_next,
    output logic [ADDRESS_BITS-1:0]         wofs_next,
    output logic [14:0]                     nm_next,
    output logic [30:0]                     el_next,
    output logic [63:0]                     dv_next,
    output logic [3:0]                      dk_next
);

    localparam int SZW = 40;
    localparam int DW  = $clog2(STACK_DEPTH);

    logic            ctx_list;
    logic            is_list;
    logic [3:0]      begin_tag;
    logic [3:0]      esz_t;
    logic [3:0]      esz_k;
    logic [SZW-1:0]  arr_body;
    logic [SZW-1:0]  body_add;
    logic [SZW-1:0]  hdr_need;
    logic [SZW-1:0]  need;
    logic [SZW-1:0]  cap_w;
    logic [SZW-1:0]  lim;
    logic [SZW-1:0]  cap_eff;
    logic            fits;
    logic            can_push;
    logic [63:0]     add_val;

    status_t         st;
    logic            le_en;
    logic [3:0]      le_t;
    logic            push;
    logic            pop;
    ctx_t            push_ctx;
    logic [1:0]      pre_n;
    logic [23:0]     pre_data;
    logic            wt_en;
    logic [3:0]      wt_k;
    logic [63:0]     wt_v;
    logic [3:0]      app_n;
    logic [63:0]     app_v;
    logic            head_set;

    logic            first;
    logic [31:0]     cnt_inc;
    logic [6:0]      shamt;
    logic [63:0]     app_al;

    assign ctx_list  = (top_ctx == CTX_LIST);
    assign is_list   = (op == OP_BEGIN_LIST);
    assign begin_tag = is_list ? TAG_LIST : TAG_COMPOUND;
    assign esz_t     = elem_len(tag_type);
    assign esz_k     = elem_len(def_kind);
    assign add_val   = (esz_t != 4'd0) ? 64'(array_length) : scalar_value;

    // array contents counted into the room check, element size is 1, 4 or 8
    always_comb begin
        case (esz_t)
            4'd1:    arr_body = SZW'(array_length);
            4'd4:    arr_body = SZW'(array_length) << 2;
            4'd8:    arr_body = SZW'(array_length) << 3;
            default: arr_body = '0;
        endcase
    end

    assign body_add = SZW'(tail_len(tag_type)) + arr_body;
    assign hdr_need = ctx_list ? '0 : (SZW'(3) + SZW'(name_length));

    always_comb begin
        unique case (op) inside
            OP_BEGIN_COMPOUND, OP_BEGIN_LIST:
                need = hdr_need + (is_list ? SZW'(5) : '0);
            OP_END_COMPOUND:  need = SZW'(1);
            OP_ADD_TAG:       need = hdr_need + body_add;
            OP_NAME_BYTE:
                need = SZW'(1) + ((names_rem == 15'd1) ? SZW'(tail_len(def_kind)) : '0);
            OP_ARRAY_ELEMENT: need = SZW'(esz_k);
            default:          need = '0;
        endcase
    end

    assign cap_w    = SZW'(capacity);
    assign lim      = SZW'(1) << ADDRESS_BITS;
    assign cap_eff  = (cap_w > lim) ? lim : cap_w;
    assign fits     = (SZW'(wofs) + need) < cap_eff;
    assign can_push = (int'(depth) + 1) < STACK_DEPTH;

    always_comb begin
        st       = ST_OK;
        le_en    = 1'b0;
        le_t     = TAG_NONE;
        push     = 1'b0;
        pop      = 1'b0;
        push_ctx = CTX_COMPOUND;
        pre_n    = 2'd0;
        pre_data = '0;
        wt_en    = 1'b0;
        wt_k     = TAG_NONE;
        wt_v     = '0;
        app_n    = 4'd0;
        app_v    = '0;
        head_set = 1'b0;
        nm_next  = names_rem;
        el_next  = elem_rem;
        dv_next  = def_val;
        dk_next  = def_kind;

        if (names_rem != 15'd0 && op != OP_NAME_BYTE) begin
            st = ST_BAD_SEQUENCE;
        end else if (elem_rem != 31'd0 && op != OP_ARRAY_ELEMENT) begin
            st = ST_BAD_SEQUENCE;
        end else begin
            unique case (op) inside
                OP_BEGIN_COMPOUND, OP_BEGIN_LIST: begin
                    if (ctx_list) begin
                        if (top_ltype != TAG_NONE && top_ltype != begin_tag) begin
                            st = ST_TYPE_MISMATCH;
                        end else if (!can_push) begin
                            st = ST_TOO_DEEP;
                        end else if (!fits) begin
                            st = ST_BUFFER_FULL;
                        end else begin
                            le_en    = 1'b1;
                            le_t     = begin_tag;
                            push     = 1'b1;
                            push_ctx = is_list ? CTX_LIST : CTX_COMPOUND;
                            wt_en    = 1'b1;
                            wt_k     = begin_tag;
                        end
                    end else if (top_ctx != CTX_COMPOUND && is_list) begin
                        st = ST_BAD_CONTEXT;
                    end else if (!can_push) begin
                        st = ST_TOO_DEEP;
                    end else if (!fits) begin
                        st = ST_BUFFER_FULL;
                    end else begin
                        push     = 1'b1;
                        push_ctx = is_list ? CTX_LIST : CTX_COMPOUND;
                        pre_n    = 2'd3;
                        pre_data = {4'd0, begin_tag, 1'b0, name_length};
                        if (name_length != 15'd0) begin
                            nm_next = name_length;
                            dk_next = begin_tag;
                            dv_next = '0;
                        end else begin
                            wt_en = 1'b1;
                            wt_k  = begin_tag;
                        end
                    end
                end
                OP_END_COMPOUND: begin
                    if (top_ctx == CTX_ROOT) begin
                        st = ST_OK;
                    end else if (top_ctx != CTX_COMPOUND) begin
                        st = ST_BAD_CONTEXT;
                    end else if (!fits) begin
                        st = ST_BUFFER_FULL;
                    end else begin
                        pop      = 1'b1;
                        pre_n    = 2'd1;
                        pre_data = '0;
                    end
                end
                OP_END_LIST: begin
                    if (!ctx_list) begin
                        st = ST_BAD_CONTEXT;
                    end else begin
                        pop = 1'b1;
                    end
                end
                OP_ADD_TAG: begin
                    if (top_ctx != CTX_COMPOUND && !ctx_list) begin
                        st = ST_BAD_CONTEXT;
                    end else if (!tag_known(tag_type)) begin
                        st = ST_BAD_SEQUENCE;
                    end else if (tag_type == TAG_STRING && array_length > 31'd65535) begin
                        st = ST_BAD_SEQUENCE;
                    end else if (!ctx_list) begin
                        if (!fits) begin
                            st = ST_BUFFER_FULL;
                        end else begin
                            pre_n    = 2'd3;
                            pre_data = {4'd0, tag_type, 1'b0, name_length};
                            if (name_length != 15'd0) begin
                                nm_next = name_length;
                                dk_next = tag_type;
                                dv_next = add_val;
                            end else begin
                                wt_en = 1'b1;
                                wt_k  = tag_type;
                                wt_v  = add_val;
                            end
                        end
                    end else if (top_ltype != TAG_NONE && top_ltype != tag_type) begin
                        st = ST_TYPE_MISMATCH;
                    end else if (!fits) begin
                        st = ST_BUFFER_FULL;
                    end else begin
                        le_en = 1'b1;
                        le_t  = tag_type;
                        wt_en = 1'b1;
                        wt_k  = tag_type;
                        wt_v  = add_val;
                    end
                end
                OP_NAME_BYTE: begin
                    if (names_rem == 15'd0) begin
                        st = ST_BAD_SEQUENCE;
                    end else if (!fits) begin
                        st = ST_BUFFER_FULL;
                    end else begin
                        pre_n    = 2'd1;
                        pre_data = {data_byte, 16'd0};
                        nm_next  = names_rem - 15'd1;
                        if (names_rem == 15'd1) begin
                            wt_en = 1'b1;
                            wt_k  = def_kind;
                            wt_v  = def_val;
                        end
                    end
                end
                OP_ARRAY_ELEMENT: begin
                    if (elem_rem == 31'd0 || esz_k == 4'd0) begin
                        st = ST_BAD_SEQUENCE;
                    end else if (!fits) begin
                        st = ST_BUFFER_FULL;
                    end else begin
                        app_n   = esz_k;
                        app_v   = (esz_k == 4'd1) ? 64'(data_byte) : scalar_value;
                        el_next = elem_rem - 31'd1;
                        if (elem_rem == 31'd1) begin
                            dk_next = TAG_NONE;
                        end
                    end
                end
                default: st = ST_BAD_SEQUENCE;
            endcase
        end

        // everything that follows a tag name
        if (wt_en) begin
            dv_next = '0;
            if (wt_k == TAG_LIST) begin
                app_n    = 4'd5;
                app_v    = '0;
                head_set = 1'b1;
                dk_next  = TAG_NONE;
            end else if (elem_len(wt_k) != 4'd0) begin
                app_n   = tail_len(wt_k);
                app_v   = wt_v;
                el_next = wt_v[30:0];
                dk_next = (wt_v[30:0] != 31'd0) ? wt_k : TAG_NONE;
            end else begin
                app_n   = tail_len(wt_k);
                app_v   = wt_v;
                dk_next = TAG_NONE;
            end
        end
    end

    // list element bookkeeping on the current top
    assign first     = (top_ltype == TAG_NONE);
    assign cnt_inc   = top_count + 32'd1;
    assign mod_ltype = (le_en && first) ? le_t : top_ltype;
    assign mod_count = le_en ? cnt_inc : top_count;

    assign rw_addr = first ? top_head : top_head + ADDRESS_BITS'(1);
    assign ap_addr = wofs;

    assign shamt  = {4'(4'd8 - app_n), 3'b000};
    assign app_al = app_v << shamt;

    always_comb begin
        plan.status  = st;
        plan.rw_n    = le_en ? (first ? 3'd5 : 3'd4) : 3'd0;
        plan.rw_data = first ? {4'd0, le_t, cnt_inc} : {cnt_inc, 8'd0};
        plan.ap_n    = {2'd0, pre_n} + app_n;
        case (pre_n)
            2'd3:    plan.ap_data = {pre_data, app_al, 8'd0};
            2'd1:    plan.ap_data = {pre_data[23:16], app_al, 24'd0};
            default: plan.ap_data = {app_al, 32'd0};
        endcase
    end

    always_comb begin
        sop.push = push;
        sop.pop  = pop;
        if (push) begin
            ctx_next   = push_ctx;
            ltype_next = TAG_NONE;
            count_next = '0;
            head_next  = '0;
        end else begin
            ctx_next   = top_ctx;
            ltype_next = mod_ltype;
            count_next = mod_count;
            head_next  = top_head;
        end
        if (head_set) begin
            head_next = wofs + ADDRESS_BITS'(pre_n);
        end
        if (push) begin
            depth_next = depth + DW'(1);
        end else if (pop) begin
            depth_next = depth - DW'(1);
        end else begin
            depth_next = depth;
        end
    end

    assign wofs_next = wofs + ADDRESS_BITS'(pre_n) + ADDRESS_BITS'(app_n);

endmodule

FILE: rtl/ntss_emit.sv
// result sequencer: plays one command's plan out as byte words and a status
// word through a registered output stage; uses ntss_pkg
`timescale 1ns / 1ps

module ntss_emit import ntss_pkg::*; #(
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     load,
    input  plan_t                    plan,
    input  logic [ADDRESS_BITS-1:0]  rw_addr,
    input  logic [ADDRESS_BITS-1:0]  ap_addr,
    output logic                     busy,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic [0:0]               m_axis_tuser,
    output logic                     m_axis_tlast
);

    emit_state_t              state_reg, state_next;
    logic [39:0]              rw_data_reg, rw_data_next;
    logic [2:0]               rw_n_reg, rw_n_next;
    logic [ADDRESS_BITS-1:0]  rw_addr_reg, rw_addr_next;
    logic [95:0]              ap_data_reg, ap_data_next;
    logic [3:0]               ap_n_reg, ap_n_next;
    logic [ADDRESS_BITS-1:0]  ap_addr_reg, ap_addr_next;
    status_t                  st_reg, st_next;
    logic                     tvalid_reg, tvalid_next;
    logic [OUT_TDATA_W-1:0]   tdata_reg;
    logic                     tuser_reg;
    logic                     tlast_reg;

    logic                     out_free;
    logic                     emit_en;
    logic                     e_user;
    logic                     e_last;
    logic [ADDRESS_BITS-1:0]  e_addr;
    logic [7:0]               e_data;
    status_t                  e_st;
    logic [31:0]              e_addr32;

    assign out_free = !tvalid_reg || m_axis_tready;

    always_comb begin
        state_next   = state_reg;
        rw_data_next = rw_data_reg;
        rw_n_next    = rw_n_reg;
        rw_addr_next = rw_addr_reg;
        ap_data_next = ap_data_reg;
        ap_n_next    = ap_n_reg;
        ap_addr_next = ap_addr_reg;
        st_next      = st_reg;
        emit_en      = 1'b0;
        e_user       = 1'b0;
        e_last       = 1'b0;
        e_addr       = '0;
        e_data       = '0;
        e_st         = ST_OK;
        unique case (state_reg)
            EM_IDLE: begin
                if (load) begin
                    rw_data_next = plan.rw_data;
                    rw_n_next    = plan.rw_n;
                    rw_addr_next = rw_addr;
                    ap_data_next = plan.ap_data;
                    ap_n_next    = plan.ap_n;
                    ap_addr_next = ap_addr;
                    st_next      = plan.status;
                    if (plan.rw_n != 3'd0) begin
                        state_next = EM_HEAD;
                    end else if (plan.ap_n != 4'd0) begin
                        state_next = EM_APPEND;
                    end else begin
                        state_next = EM_STATUS;
                    end
                end
            end
            EM_HEAD: begin
                if (out_free) begin
                    emit_en      = 1'b1;
                    e_addr       = rw_addr_reg;
                    e_data       = rw_data_reg[39:32];
                    rw_data_next = rw_data_reg << 8;
                    rw_addr_next = rw_addr_reg + ADDRESS_BITS'(1);
                    rw_n_next    = rw_n_reg - 3'd1;
                    if (rw_n_reg == 3'd1) begin
                        state_next = (ap_n_reg != 4'd0) ? EM_APPEND : EM_STATUS;
                    end
                end
            end
            EM_APPEND: begin
                if (out_free) begin
                    emit_en      = 1'b1;
                    e_addr       = ap_addr_reg;
                    e_data       = ap_data_reg[95:88];
                    ap_data_next = ap_data_reg << 8;
                    ap_addr_next = ap_addr_reg + ADDRESS_BITS'(1);
                    ap_n_next    = ap_n_reg - 4'd1;
                    if (ap_n_reg == 4'd1) begin
                        state_next = EM_STATUS;
                    end
                end
            end
            EM_STATUS: begin
                if (out_free) begin
                    emit_en    = 1'b1;
                    e_user     = 1'b1;
                    e_last     = 1'b1;
                    e_st       = st_reg;
                    state_next = EM_IDLE;
                end
            end
            default: state_next = EM_IDLE;
        endcase
    end

    assign e_addr32 = 32'(e_addr);

    always_comb begin
        if (emit_en) begin
            tvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            tvalid_next = 1'b0;
        end else begin
            tvalid_next = tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= EM_IDLE;
            tvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            tvalid_reg <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rw_data_reg <= rw_data_next;
        rw_n_reg    <= rw_n_next;
        rw_addr_reg <= rw_addr_next;
        ap_data_reg <= ap_data_next;
        ap_n_reg    <= ap_n_next;
        ap_addr_reg <= ap_addr_next;
        st_reg      <= st_next;
        if (emit_en) begin
            tdata_reg <= {5'd0, e_st, e_data, e_addr32[15:0]};
            tuser_reg <= e_user;
            tlast_reg <= e_last;
        end
    end

    assign busy            = (state_reg != EM_IDLE);
    assign m_axis_tvalid   = tvalid_reg;
    assign m_axis_tdata    = tdata_reg;
    assign m_axis_tuser[0] = tuser_reg;
    assign m_axis_tlast    = tlast_reg;

endmodule

FILE: rtl/nested_tag_stream_serializer_core.sv
// top level of the nested tag stream serializer: command slot, stack top cache,
// writer state; uses ntss_pkg, ntss_stack, ntss_decode, ntss_emit
`timescale 1ns / 1ps

// usage
//  - s_axis carries one command word: opcode in tuser, the operands in tdata;
//    a word is taken when tvalid and tready are both high
//  - m_axis returns, per command, one word per buffer byte write (tuser 0,
//    address and byte) and then one status word (tuser 1, tlast 1)
//  - cfg_valid/cfg_data write buffer_capacity; cfg_ready is always high;
//    write it only while no command is in flight
//  - a command is decoded while it sits in the command slot, the sequencer is
//    free and no stack top reload is pending; its words then follow one per
//    cycle unless m_axis_tready holds the output word
//  - bytes written per command: list head rewrite plus appended bytes, up to
//    13, each through the single byte-wide output stage
//  - the command slot frees when its command is decoded, so the next command
//    is taken while earlier words are still draining
//  - the nesting stack lives in a small memory; the top level is cached in
//    registers, a pop reloads it from the memory's registered read port,
//    covered by the status word that every command emits
//  - reset (aresetn low, synchronous) empties the slot and output stage, puts
//    the writer at root level, offset 0, and capacity 65536; no clearing pass
//  - when m_axis_tready is low the output word holds, the sequencer waits,
//    and once the slot is full s_axis_tready drops
module nested_tag_stream_serializer_core import ntss_pkg::*; #(
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    // tag_type[3:0], name_length[18:4], scalar_value[82:19],
    // array_length[113:83], data_byte[121:114], zeros above
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    // opcode[2:0]
    input  logic [2:0]              s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    // write_address[15:0], write_data[23:16], status[26:24], zeros above
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    // kind[0]
    output logic [0:0]              m_axis_tuser,
    output logic                    m_axis_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CAP_W-1:0]        cfg_data
);

    localparam int DW      = $clog2(STACK_DEPTH);
    localparam int ENTRY_W = 2 + 4 + 32 + ADDRESS_BITS;

    // command slot
    logic                     item_valid_reg;
    opcode_t                  item_op_reg;
    logic [3:0]               item_type_reg;
    logic [14:0]              item_nl_reg;
    logic [63:0]              item_sv_reg;
    logic [30:0]              item_len_reg;
    logic [7:0]               item_byte_reg;

    // writer state, stack top cached
    ctx_t                     top_ctx_reg, top_ctx_next;
    logic [3:0]               top_ltype_reg, top_ltype_next;
    logic [31:0]              top_count_reg, top_count_next;
    logic [ADDRESS_BITS-1:0]  top_head_reg, top_head_next;
    logic [DW-1:0]            depth_reg, depth_next;
    logic [ADDRESS_BITS-1:0]  wofs_reg, wofs_next;
    logic [14:0]              names_rem_reg, names_rem_next;
    logic [30:0]              elem_rem_reg, elem_rem_next;
    logic [63:0]              def_val_reg, def_val_next;
    logic [3:0]               def_kind_reg, def_kind_next;
    logic [CAP_W-1:0]         cap_reg;
    logic                     pop_load_reg;

    logic                     s_fire;
    logic                     dec_fire;
    logic                     emit_busy;
    plan_t                    plan;
    logic [ADDRESS_BITS-1:0]  rw_addr;
    logic [ADDRESS_BITS-1:0]  ap_addr;
    stack_op_t                sop;
    logic [3:0]               mod_ltype;
    logic [31:0]              mod_count;
    logic [ENTRY_W-1:0]       mem_wdata;
    logic [ENTRY_W-1:0]       mem_rdata;

    assign s_axis_tready = !item_valid_reg;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // decode when a command waits, the sequencer is free and no reload pending
    assign dec_fire = item_valid_reg && !emit_busy && !pop_load_reg;

    ntss_decode #(
        .STACK_DEPTH  (STACK_DEPTH),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_decode (
        .op           (item_op_reg),
        .tag_type     (item_type_reg),
        .name_length  (item_nl_reg),
        .scalar_value (item_sv_reg),
        .array_length (item_len_reg),
        .data_byte    (item_byte_reg),
        .top_ctx      (top_ctx_reg),
        .top_ltype    (top_ltype_reg),
        .top_count    (top_count_reg),
        .top_head     (top_head_reg),
        .depth        (depth_reg),
        .wofs         (wofs_reg),
        .names_rem    (names_rem_reg),
        .elem_rem     (elem_rem_reg),
        .def_val      (def_val_reg),
        .def_kind     (def_kind_reg),
        .capacity     (cap_reg),
        .plan         (plan),
        .rw_addr      (rw_addr),
        .ap_addr      (ap_addr),
        .sop          (sop),
        .mod_ltype    (mod_ltype),
        .mod_count    (mod_count),
        .ctx_next     (top_ctx_next),
        .ltype_next   (top_ltype_next),
        .count_next   (top_count_next),
        .head_next    (top_head_next),
        .depth_next   (depth_next),
        .wofs_next    (wofs_next),
        .nm_next      (names_rem_next),
        .el_next      (elem_rem_next),
        .dv_next      (def_val_next),
        .dk_next      (def_kind_next)
    );

    // a push parks the updated parent level at its own depth
    assign mem_wdata = {top_ctx_reg, mod_ltype, mod_count, top_head_reg};

    ntss_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .ENTRY_W     (ENTRY_W)
    ) u_stack (
        .aclk  (aclk),
        .we    (dec_fire && sop.push),
        .waddr (depth_reg),
        .wdata (mem_wdata),
        .re    (dec_fire && sop.pop),
        .raddr (depth_reg - DW'(1)),
        .rdata (mem_rdata)
    );

    ntss_emit #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_emit (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (dec_fire),
        .plan          (plan),
        .rw_addr       (rw_addr),
        .ap_addr       (ap_addr),
        .busy          (emit_busy),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // command slot payload, no reset
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_op_reg   <= opcode_t'(s_axis_tuser);
            item_type_reg <= s_axis_tdata[3:0];
            item_nl_reg   <= s_axis_tdata[18:4];
            item_sv_reg   <= s_axis_tdata[82:19];
            item_len_reg  <= s_axis_tdata[113:83];
            item_byte_reg <= s_axis_tdata[121:114];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            top_ctx_reg    <= CTX_ROOT;
            top_ltype_reg  <= TAG_NONE;
            top_count_reg  <= '0;
            top_head_reg   <= '0;
            depth_reg      <= '0;
            wofs_reg       <= '0;
            names_rem_reg  <= '0;
            elem_rem_reg   <= '0;
            def_val_reg    <= '0;
            def_kind_reg   <= TAG_NONE;
            cap_reg        <= CAP_RESET;
            pop_load_reg   <= 1'b0;
        end else begin
            if (s_fire) begin
                item_valid_reg <= 1'b1;
            end else if (dec_fire) begin
                item_valid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            pop_load_reg <= dec_fire && sop.pop;
            if (pop_load_reg) begin
                // new top arrives from the stack memory
                top_ctx_reg   <= ctx_t'(mem_rdata[ENTRY_W-1 -: 2]);
                top_ltype_reg <= mem_rdata[ENTRY_W-3 -: 4];
                top_count_reg <= mem_rdata[ADDRESS_BITS +: 32];
                top_head_reg  <= mem_rdata[ADDRESS_BITS-1:0];
            end else if (dec_fire) begin
                top_ctx_reg   <= top_ctx_next;
                top_ltype_reg <= top_ltype_next;
                top_count_reg <= top_count_next;
                top_head_reg  <= top_head_next;
            end
            if (dec_fire) begin
                depth_reg     <= depth_next;
                wofs_reg      <= wofs_next;
                names_rem_reg <= names_rem_next;
                elem_rem_reg  <= elem_rem_next;
                def_val_reg   <= def_val_next;
                def_kind_reg  <= def_kind_next;
            end
        end
    end

    // a reload of the stack top never overlaps a decode
    a_pop_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire |-> !pop_load_reg)
        else $error("decode during stack top reload");

    // root context only at level zero
    a_root_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (top_ctx_reg == CTX_ROOT && !pop_load_reg) |-> (depth_reg == '0))
        else $error("root context above level zero");

    // names and array contents are never owed at once
    a_owed: assert property (@(posedge aclk) disable iff (!aresetn)
        !(names_rem_reg != '0 && elem_rem_reg != '0))
        else $error("names and elements owed together");

    // every decoded command keeps the sequencer busy until its status word
    a_dec_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        dec_fire |=> emit_busy)
        else $error("sequencer idle after decode");

    // only status words end a command
    a_last_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast))
        else $error("tlast does not match status word");

endmodule

FILE: test/tb_top.sv
// self-checking testbench for nested_tag_stream_serializer_core: directed table, then
// random command streams checked word by word against an in-bench serializer model
// depends on rtl/ntss_pkg.sv and rtl/nested_tag_stream_serializer_core.sv
`timescale 1ns / 1ps

module tb_top;
    import ntss_pkg::*;

    localparam int LEVELS     = 16;
    localparam int WDOG_LIMIT = 20000;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [7:0]  data;
        logic [2:0]  st;
        logic        last;
    } out_word_t;

    typedef struct {
        opcode_t     op;
        logic [3:0]  tag;
        logic [14:0] nl;
        logic [63:0] sv;
        logic [30:0] len;
        logic [7:0]  byt;
        status_t     st;
        bit          chk;
    } cmd_t;

    // dut ports
    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [2:0]             s_axis_tuser = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;
    logic                   m_axis_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CAP_W-1:0]       cfg_data = '0;

    // model state of the writer
    logic [16:0] capacity;
    ctx_t        lvl_ctx[LEVELS];
    logic [3:0]  lvl_ltype[LEVELS];
    logic [31:0] lvl_count[LEVELS];
    logic [63:0] lvl_head[LEVELS];
    int unsigned depth;
    logic [63:0] wr_off;
    int unsigned names_owed;
    int unsigned elems_owed;
    logic [63:0] held_value;
    logic [3:0]  held_kind;

    out_word_t pending_words[$];
    cmd_t      table_rows[$];

    int err_count = 0;
    int cmd_count = 0;
    int word_count = 0;
    int status_seen[8];
    int deepest_level = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int recv_hold = 0;
    int wdog = 0;

    nested_tag_stream_serializer_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------- serializer model

    // bytes following the name of a tag
    function automatic int unsigned tail_size(input logic [3:0] k);
        case (k)
            4'd1:                return 1;
            4'd2, 4'd8:          return 2;
            4'd3, 4'd5, 4'd7:    return 4;
            4'd11, 4'd12:        return 4;
            4'd4, 4'd6:          return 8;
            4'd9:                return 5;
            default:             return 0;
        endcase
    endfunction

    // bytes per array or string element
    function automatic int unsigned elem_size(input logic [3:0] k);
        case (k)
            4'd7, 4'd8: return 1;
            4'd11:      return 4;
            4'd12:      return 8;
            default:    return 0;
        endcase
    endfunction

    function automatic void writer_reset();
        capacity = CAP_RESET;
        for (int i = 0; i < LEVELS; i++) begin
            lvl_ctx[i] = CTX_ROOT;
            lvl_ltype[i] = '0;
            lvl_count[i] = '0;
            lvl_head[i] = '0;
        end
        depth = 0;
        wr_off = '0;
        names_owed = 0;
        elems_owed = 0;
        held_value = '0;
        held_kind = '0;
    endfunction

    function automatic bit room_for(input logic [63:0] n);
        logic [63:0] cap;
        cap = (capacity > 17'h10000) ? 64'h10000 : 64'(capacity);
        return (wr_off + n) < cap;
    endfunction

    function automatic void put_byte(input logic [63:0] addr, input logic [7:0] val);
        pending_words.push_back('{1'b0, addr[15:0], val, 3'd0, 1'b0});
    endfunction

    // big-endian append at the write offset
    function automatic void append_be(input logic [63:0] v, input int unsigned nb);
        for (int i = nb; i > 0; i--) begin
            put_byte(wr_off, v[8*(i-1) +: 8]);
            wr_off = wr_off + 1;
        end
    endfunction

    function automatic void push_level(input ctx_t c);
        if (depth + 1 >= LEVELS)
            return;
        depth = depth + 1;
        lvl_ctx[depth] = c;
        lvl_ltype[depth] = '0;
        lvl_count[depth] = '0;
        lvl_head[depth] = '0;
        if (depth > deepest_level)
            deepest_level = depth;
    endfunction

    // one more element in the open list: type byte once, then the count rewrite
    function automatic void count_element(input logic [3:0] t);
        logic [63:0] h;
        h = lvl_head[depth];
        if (lvl_ltype[depth] == 4'd0) begin
            lvl_ltype[depth] = t;
            put_byte(h, {4'd0, t});
        end
        lvl_count[depth] = lvl_count[depth] + 1;
        for (int i = 0; i < 4; i++)
            put_byte(h + 1 + i, lvl_count[depth][8*(3-i) +: 8]);
    endfunction

    function automatic void write_tail(input logic [3:0] k, input logic [63:0] value);
        held_kind = k;
        held_value = '0;
        if (k == TAG_LIST) begin
            lvl_head[depth] = wr_off;
            append_be(64'd0, 5);
            held_kind = '0;
        end else if (elem_size(k) != 0) begin
            append_be(value, tail_size(k));
            elems_owed = value[30:0];
            if (elems_owed == 0)
                held_kind = '0;
        end else begin
            append_be(value, tail_size(k));
            held_kind = '0;
        end
    endfunction

    function automatic void tag_header(input logic [3:0] t, input logic [14:0] nl,
                                       input logic [63:0] value);
        append_be(64'(t), 1);
        append_be(64'(nl), 2);
        if (nl != 0) begin
            names_owed = nl;
            held_kind = t;
            held_value = value;
        end else begin
            write_tail(t, value);
        end
    endfunction

    function automatic status_t open_nested(input bit is_list, input logic [14:0] nl);
        ctx_t        c;
        logic [3:0]  t;
        logic [63:0] body;
        c = lvl_ctx[depth];
        t = is_list ? TAG_LIST : TAG_COMPOUND;
        body = is_list ? 64'd5 : 64'd0;
        if (c == CTX_LIST) begin
            if (lvl_ltype[depth] != 4'd0 && lvl_ltype[depth] != t)
                return ST_TYPE_MISMATCH;
            if (depth + 1 >= LEVELS)
                return ST_TOO_DEEP;
            if (!room_for(body))
                return ST_BUFFER_FULL;
            count_element(t);
            push_level(is_list ? CTX_LIST : CTX_COMPOUND);
            write_tail(t, 64'd0);
            return ST_OK;
        end
        if (c != CTX_COMPOUND && is_list)
            return ST_BAD_CONTEXT;
        if (depth + 1 >= LEVELS)
            return ST_TOO_DEEP;
        if (!room_for(64'd3 + 64'(nl) + body))
            return ST_BUFFER_FULL;
        push_level(is_list ? CTX_LIST : CTX_COMPOUND);
        tag_header(t, nl, 64'd0);
        return ST_OK;
    endfunction

    function automatic status_t add_tag(input cmd_t c);
        ctx_t        ctx;
        logic [63:0] body;
        logic [63:0] value;
        bit          arr;
        ctx = lvl_ctx[depth];
        if (ctx != CTX_COMPOUND && ctx != CTX_LIST)
            return ST_BAD_CONTEXT;
        if (c.tag == 4'd0 || c.tag == TAG_LIST || c.tag == TAG_COMPOUND || c.tag > 4'd12)
            return ST_BAD_SEQUENCE;
        if (c.tag == TAG_STRING && c.len > 31'd65535)
            return ST_BAD_SEQUENCE;
        arr = elem_size(c.tag) != 0;
        body = 64'(tail_size(c.tag)) + (arr ? 64'(c.len) * 64'(elem_size(c.tag)) : 64'd0);
        value = arr ? 64'(c.len) : c.sv;
        if (ctx == CTX_COMPOUND) begin
            if (!room_for(64'd3 + 64'(c.nl) + body))
                return ST_BUFFER_FULL;
            tag_header(c.tag, c.nl, value);
            return ST_OK;
        end
        if (lvl_ltype[depth] != 4'd0 && lvl_ltype[depth] != c.tag)
            return ST_TYPE_MISMATCH;
        if (!room_for(body))
            return ST_BUFFER_FULL;
        count_element(c.tag);
        write_tail(c.tag, value);
        return ST_OK;
    endfunction

    function automatic status_t name_byte(input logic [7:0] b);
        logic [63:0] n;
        logic [3:0]  k;
        k = held_kind;
        n = 64'd1;
        if (names_owed == 0)
            return ST_BAD_SEQUENCE;
        if (names_owed == 1)
            n = n + tail_size(k);
        if (!room_for(n))
            return ST_BUFFER_FULL;
        append_be(64'(b), 1);
        names_owed = names_owed - 1;
        if (names_owed == 0)
            write_tail(k, held_value);
        return ST_OK;
    endfunction

    function automatic status_t array_element(input logic [7:0] b, input logic [63:0] sv);
        int unsigned sz;
        sz = elem_size(held_kind);
        if (elems_owed == 0 || sz == 0)
            return ST_BAD_SEQUENCE;
        if (!room_for(64'(sz)))
            return ST_BUFFER_FULL;
        append_be(sz == 1 ? 64'(b) : sv, sz);
        elems_owed = elems_owed - 1;
        if (elems_owed == 0)
            held_kind = '0;
        return ST_OK;
    endfunction

    // queues the words one command produces, returns its status
    function automatic status_t serialize(input cmd_t c);
        status_t st;
        ctx_t    ctx;
        st = ST_OK;
        ctx = lvl_ctx[depth];
        if (names_owed > 0 && c.op != OP_NAME_BYTE)
            st = ST_BAD_SEQUENCE;
        else if (elems_owed > 0 && c.op != OP_ARRAY_ELEMENT)
            st = ST_BAD_SEQUENCE;
        else begin
            case (c.op)
                OP_BEGIN_COMPOUND: st = open_nested(1'b0, c.nl);
                OP_END_COMPOUND: begin
                    if (ctx == CTX_ROOT)
                        st = ST_OK;
                    else if (ctx != CTX_COMPOUND)
                        st = ST_BAD_CONTEXT;
                    else if (!room_for(64'd1))
                        st = ST_BUFFER_FULL;
                    else begin
                        depth = depth - 1;
                        append_be(64'd0, 1);
                    end
                end
                OP_BEGIN_LIST: st = open_nested(1'b1, c.nl);
                OP_END_LIST: begin
                    if (ctx != CTX_LIST)
                        st = ST_BAD_CONTEXT;
                    else
                        depth = depth - 1;
                end
                OP_ADD_TAG:       st = add_tag(c);
                OP_NAME_BYTE:     st = name_byte(c.byt);
                OP_ARRAY_ELEMENT: st = array_element(c.byt, c.sv);
                default:          st = ST_BAD_SEQUENCE;
            endcase
        end
        pending_words.push_back('{1'b1, 16'd0, 8'd0, st, 1'b1});
        return st;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic cmd_t row(input opcode_t op, input logic [3:0] tag,
                                 input logic [14:0] nl, input logic [63:0] sv,
                                 input logic [30:0] len, input logic [7:0] b,
                                 input status_t st);
        cmd_t c;
        c = '{op, tag, nl, sv, len, b, st, 1'b1};
        return c;
    endfunction

    function automatic logic [3:0] known_tag();
        logic [3:0] t;
        t = 4'($urandom_range(1, 10));
        return (t == 4'd9) ? 4'd11 : (t == 4'd10) ? 4'd12 : t;
    endfunction

    // mostly well-formed commands that follow the writer state, some noise
    function automatic cmd_t next_cmd(input bit deep);
        cmd_t c;
        int   r;
        c.tag = known_tag();
        c.nl = 15'($urandom_range(0, 3));
        c.sv = {$urandom, $urandom};
        c.len = 31'($urandom_range(0, 4));
        c.byt = 8'($urandom);
        c.chk = 1'b0;
        c.st = ST_OK;
        r = $urandom_range(99);
        if (r < 8) begin
            // noise: any opcode, any type; wide sizes only where they cannot open a tag
            c.op = opcode_t'($urandom_range(0, 7));
            c.tag = 4'($urandom);
            if (!(c.op inside {OP_BEGIN_COMPOUND, OP_BEGIN_LIST, OP_ADD_TAG})) begin
                c.nl = 15'($urandom);
                c.len = 31'($urandom);
            end
        end else if (names_owed > 0) begin
            c.op = OP_NAME_BYTE;
        end else if (elems_owed > 0) begin
            c.op = OP_ARRAY_ELEMENT;
        end else begin
            r = $urandom_range(99);
            if (r < (deep ? 35 : 15))
                c.op = OP_BEGIN_COMPOUND;
            else if (r < (deep ? 70 : 30))
                c.op = OP_BEGIN_LIST;
            else if (r < (deep ? 76 : 45))
                c.op = OP_END_COMPOUND;
            else if (r < (deep ? 82 : 60))
                c.op = OP_END_LIST;
            else
                c.op = OP_ADD_TAG;
            // in a typed list keep to its type most of the time
            if (lvl_ctx[depth] == CTX_LIST && lvl_ltype[depth] != 4'd0
                    && $urandom_range(99) < 80) begin
                if (lvl_ltype[depth] == TAG_LIST)
                    c.op = OP_BEGIN_LIST;
                else if (lvl_ltype[depth] == TAG_COMPOUND)
                    c.op = OP_BEGIN_COMPOUND;
                else
                    c.tag = lvl_ltype[depth];
            end
        end
        return c;
    endfunction

    task automatic send_cmd(input cmd_t c);
        status_t st;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = c.op;
        s_axis_tdata = {6'd0, c.byt, c.len, c.sv, c.nl, c.tag};
        do @(posedge aclk); while (!s_axis_tready);
        st = serialize(c);
        cmd_count++;
        status_seen[st]++;
        if (c.chk && st != c.st) begin
            $error("table row op %s: status expected %0d, model gives %0d",
                   c.op.name(), c.st, st);
            err_count++;
        end
    endtask

    // sender pauses until every queued word has come back, then stays quiet
    task automatic drain();
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        wait (pending_words.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic set_capacity(input logic [16:0] v);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data = v;
        do @(posedge aclk); while (!cfg_ready);
        capacity = v;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // ---------------------------------------------------------------- receiver, monitor

    // stalls at random; a hold-off count forces a long stretch with tready low
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            m_axis_tready = 1'b0;
            recv_hold = recv_hold - 1;
        end else begin
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            word_count++;
            if (pending_words.size() == 0) begin
                $error("unexpected word tdata %0h tuser %0h", m_axis_tdata, m_axis_tuser);
                err_count++;
            end else begin
                want = pending_words.pop_front();
                if (m_axis_tuser[0] !== want.kind) begin
                    $error("kind expected %0h actual %0h", want.kind, m_axis_tuser[0]);
                    err_count++;
                end
                if (m_axis_tdata[15:0] !== want.addr) begin
                    $error("write_address expected %0h actual %0h",
                           want.addr, m_axis_tdata[15:0]);
                    err_count++;
                end
                if (m_axis_tdata[23:16] !== want.data) begin
                    $error("write_data expected %0h actual %0h",
                           want.data, m_axis_tdata[23:16]);
                    err_count++;
                end
                if (m_axis_tdata[26:24] !== want.st) begin
                    $error("status expected %0h actual %0h", want.st, m_axis_tdata[26:24]);
                    err_count++;
                end
                if (m_axis_tlast !== want.last) begin
                    $error("last expected %0h actual %0h", want.last, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            wdog = 0;
        else
            wdog = wdog + 1;
        if (wdog >= WDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WDOG_LIMIT);
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        bit         deep;
        int         n_items;
        logic [16:0] cap;
        writer_reset();
        for (int i = 0; i < 8; i++)
            status_seen[i] = 0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed table: root rules, bad codes, owed names and elements, lists
        table_rows.push_back(row(OP_END_COMPOUND, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_BEGIN_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_CONTEXT));
        table_rows.push_back(row(OP_END_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_CONTEXT));
        table_rows.push_back(row(OP_ADD_TAG, 4'd1, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_CONTEXT));
        table_rows.push_back(row(OP_NAME_BYTE, 4'd0, 15'd0, 64'd0, 31'd0, 8'h41,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_ARRAY_ELEMENT, 4'd0, 15'd0, 64'd0, 31'd0, 8'h41,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_UNUSED, 4'hf, 15'h7fff, '1, '1, 8'hff,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_BEGIN_COMPOUND, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_ADD_TAG, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_ADD_TAG, TAG_LIST, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_ADD_TAG, 4'hf, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_SEQUENCE));
        // string longer than a 16-bit length
        table_rows.push_back(row(OP_ADD_TAG, TAG_STRING, 15'd0, 64'd0, 31'd65536, 8'd0,
                                 ST_BAD_SEQUENCE));
        // largest name and array size cannot fit the buffer
        table_rows.push_back(row(OP_ADD_TAG, 4'd7, 15'h7fff, 64'd0, 31'h7fff_ffff, 8'd0,
                                 ST_BUFFER_FULL));
        table_rows.push_back(row(OP_ADD_TAG, 4'd4, 15'd2, 64'h8000_0000_0000_0000, 31'd0,
                                 8'd0, ST_OK));
        table_rows.push_back(row(OP_END_COMPOUND, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_NAME_BYTE, 4'd0, 15'd0, 64'd0, 31'd0, 8'h00, ST_OK));
        table_rows.push_back(row(OP_NAME_BYTE, 4'd0, 15'd0, 64'd0, 31'd0, 8'hff, ST_OK));
        table_rows.push_back(row(OP_ADD_TAG, 4'd12, 15'd0, 64'd0, 31'd1, 8'd0, ST_OK));
        table_rows.push_back(row(OP_END_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_SEQUENCE));
        table_rows.push_back(row(OP_ARRAY_ELEMENT, 4'd0, 15'd0, 64'h7fff_ffff_ffff_ffff,
                                 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_END_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_CONTEXT));
        table_rows.push_back(row(OP_BEGIN_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_ADD_TAG, 4'd1, 15'd0, 64'hff, 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_ADD_TAG, 4'd3, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_TYPE_MISMATCH));
        table_rows.push_back(row(OP_END_COMPOUND, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0,
                                 ST_BAD_CONTEXT));
        table_rows.push_back(row(OP_END_LIST, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0, ST_OK));
        table_rows.push_back(row(OP_END_COMPOUND, 4'd0, 15'd0, 64'd0, 31'd0, 8'd0, ST_OK));
        foreach (table_rows[i])
            send_cmd(table_rows[i]);
        drain();

        // random phases: capacity, idling and nesting pressure vary per phase
        for (int p = 0; p < 6; p++) begin
            deep = 1'b0;
            case (p)
                0: begin cap = 17'h10000; send_idle_pct = 0;  recv_stall_pct = 0;  n_items = 80; end
                1: begin cap = 17'h10000; send_idle_pct = 68; recv_stall_pct = 0;  n_items = 60; end
                2: begin cap = 17'd1;     send_idle_pct = 0;  recv_stall_pct = 68; n_items = 30; end
                3: begin
                    // leaves a few hundred bytes so the buffer runs full
                    cap = 17'(wr_off) + 17'($urandom_range(100, 400));
                    send_idle_pct = 23; recv_stall_pct = 23; n_items = 90;
                end
                4: begin cap = 17'h1ffff; send_idle_pct = 0;  recv_stall_pct = 0;  n_items = 90;
                         deep = 1'b1; end
                default: begin cap = 17'h10000; send_idle_pct = 23; recv_stall_pct = 68;
                               n_items = 50; end
            endcase
            set_capacity(cap);
            for (int i = 0; i < n_items; i++) begin
                // long receiver hold-off while the sender keeps offering words
                if ((p == 0 || p == 4) && i == 10)
                    recv_hold = 300;
                send_cmd(next_cmd(deep));
            end
            drain();
        end

        if (pending_words.size() != 0) begin
            $error("%0d expected words never arrived", pending_words.size());
            err_count++;
        end
        $display("covered %0d commands, %0d output words, deepest level %0d", cmd_count,
                 word_count, deepest_level);
        $display("status counts ok %0d ctx %0d mismatch %0d deep %0d full %0d seq %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
